// ----- hdl/ffha_pkg.sv -----
// Shared constants, types and codes for the first-fit heap allocator.
// No dependencies; the files that use it refer to it by scoped names.
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 16;

  localparam int ADDR_W    = 32;
  localparam int IDX_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int TOT_W     = ADDR_W + 1;
  localparam int SUM_W     = ADDR_W + 2;
  localparam int ENTRY_W   = 2 * ADDR_W;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOHEAP   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_SHIFT,
    S_PLACE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] data_address;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic              start_wr;
    logic [ADDR_W-1:0] value;
  } start_evt_t;

endpackage

// ----- hdl/ffha_req_if.sv -----
// Request channel: command word with its operands.
// Depends on ffha_pkg.
interface ffha_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [ffha_pkg::ADDR_W-1:0] request_size;
  logic [ffha_pkg::ADDR_W-1:0] block_address;
  modport source (output valid, command, request_size, block_address, input ready);
  modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

// ----- hdl/ffha_rsp_if.sv -----
// Response channel: data address and status word.
// Depends on ffha_pkg.
interface ffha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ffha_pkg::ADDR_W-1:0] data_address;
  logic [1:0]                  status;
  modport source (output valid, data_address, status, input ready);
  modport sink   (input valid, data_address, status, output ready);
endinterface

// ----- hdl/ffha_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on ffha_pkg.
interface ffha_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ffha_pkg::CFG_IDX_W-1:0] index;
  logic [ffha_pkg::ADDR_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: config registers, result register,
// table RAM and sequencer. Depends on ffha_pkg, the channel interfaces,
// ffha_ram and ffha_engine.
//
//   channel | dir | word                                     | accepted when
//   req     | in  | command, request_size, block_address     | req.valid & req.ready
//   rsp     | out | data_address, status                     | rsp.valid & rsp.ready
//   cfg     | in  | index (0 heap_start, 1 heap_limit), data | cfg.valid & cfg.ready
//
// One request is worked at a time. An allocate walks the table one entry a cycle
// (the RAM read port sets this) up to the insert point, then shifts the entries
// above it one a cycle and writes the new entry; if no gap fits it walks the whole
// table and places the entry at the break, and a full table is answered unwalked.
// A free walks to the match and shifts the rest down.
// Reset (synchronous) empties the table and clears the config registers; the RAM
// needs no clearing pass since only entries below the live count are read. The
// result sits in an output register, so a stalled rsp holds the word while the
// engine stops only once its next result is ready.
module first_fit_heap_allocator (
  input  logic           clk,
  input  logic           rst,
  ffha_req_if.sink       req,
  ffha_rsp_if.source     rsp,
  ffha_cfg_if.sink       cfg
);
  logic [ffha_pkg::ADDR_W-1:0]  heap_start;
  logic [ffha_pkg::ADDR_W-1:0]  heap_limit;
  ffha_pkg::start_evt_t         start_evt;
  ffha_pkg::mem_req_t           mem_req;
  logic [ffha_pkg::ENTRY_W-1:0] mem_rdata;
  logic                         res_valid;
  ffha_pkg::result_t            res;
  logic                         slot_free;
  logic                         o_valid;
  ffha_pkg::result_t            o_res;

  // config writes are always taken
  assign cfg.ready = 1'b1;
  assign start_evt.start_wr = cfg.valid && cfg.index == ffha_pkg::REG_HEAP_START;
  assign start_evt.value    = cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= '0;
      heap_limit <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ffha_pkg::REG_HEAP_START: heap_start <= cfg.data;
        ffha_pkg::REG_HEAP_LIMIT: heap_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  ffha_ram #(
    .WIDTH(ffha_pkg::ENTRY_W),
    .DEPTH(ffha_pkg::MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

  ffha_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .command      (req.command),
    .request_size (req.request_size),
    .block_address(req.block_address),
    .heap_start   (heap_start),
    .heap_limit   (heap_limit),
    .start_evt    (start_evt),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (slot_free)
  );

  // output register: load when empty or being drained
  assign slot_free = !o_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (slot_free) begin
      o_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) o_res <= res;
  end

  assign rsp.valid        = o_valid;
  assign rsp.data_address = o_res.data_address;
  assign rsp.status       = o_res.status;

  a_load: assert property (@(posedge clk) disable iff (rst)
    res_valid && slot_free |=> o_valid)
    else $error("result word not loaded into output register");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !res_valid)
    else $error("request taken while a result is pending");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_res.status != ffha_pkg::ST_OK |-> o_res.data_address == '0)
    else $error("failed request carries a nonzero address");
endmodule

// ----- hdl/ffha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/ffha_engine.sv -----
// Allocation/free sequencer: walks, shifts and updates the block table RAM.
// Depends on ffha_pkg; drives one ffha_ram through a mem_req_t.
module ffha_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [ffha_pkg::ADDR_W-1:0]  request_size,
  input  logic [ffha_pkg::ADDR_W-1:0]  block_address,
  input  logic [ffha_pkg::ADDR_W-1:0]  heap_start,
  input  logic [ffha_pkg::ADDR_W-1:0]  heap_limit,
  input  ffha_pkg::start_evt_t         start_evt,
  output ffha_pkg::mem_req_t           mem_req,
  input  logic [ffha_pkg::ENTRY_W-1:0] mem_rdata,
  output logic                         res_valid,
  output ffha_pkg::result_t            res,
  input  logic                         res_take
);
  localparam int AW = ffha_pkg::ADDR_W;
  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;
  localparam int TW = ffha_pkg::TOT_W;
  localparam int SW = ffha_pkg::SUM_W;

  ffha_pkg::state_t state, state_next;

  logic          op;
  logic [TW-1:0] total;
  logic [AW-1:0] faddr;
  logic [CW-1:0] count;
  logic [AW-1:0] brk;
  logic [CW-1:0] ptr;
  logic          more;
  logic          rv;
  logic [IW-1:0] eidx;
  logic [CW-1:0] pos;
  logic [AW-1:0] new_hdr;
  logic [SW-1:0] below_top;
  logic [AW-1:0] r_addr;
  ffha_pkg::status_t r_status;

  logic [AW-1:0] hdr_e, size_e;
  logic [SW-1:0] top_e;
  logic          fit, brk_fit, start_fit, last, match;
  logic [TW-1:0] tot_in;

  assign hdr_e  = mem_rdata[ffha_pkg::ENTRY_W-1:AW];
  assign size_e = mem_rdata[AW-1:0];
  assign top_e  = SW'(hdr_e) + SW'(ffha_pkg::HEADER_BYTES) + SW'(size_e);
  assign fit    = (eidx == '0) ? (SW'(heap_start) + SW'(total) < SW'(hdr_e))
                               : (below_top + SW'(total) <= SW'(hdr_e));
  assign brk_fit   = SW'(brk) + SW'(total) <= SW'(heap_limit);
  assign start_fit = SW'(heap_start) + SW'(total) <= SW'(heap_limit);
  assign last   = (CW'(eidx) == count - CW'(1));
  assign match  = SW'(hdr_e) + SW'(ffha_pkg::HEADER_BYTES) == SW'(faddr);
  assign tot_in = (TW'(request_size) + TW'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES - 1))
                  & ~TW'(ffha_pkg::ALIGN_BYTES - 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::S_IDLE:  if (in_valid) state_next = ffha_pkg::S_START;
      ffha_pkg::S_START: begin
        if (op == ffha_pkg::CMD_ALLOC) begin
          if (count == CW'(ffha_pkg::MAX_BLOCKS)) state_next = ffha_pkg::S_RESP;
          else if (count == '0) state_next = start_fit ? ffha_pkg::S_PLACE : ffha_pkg::S_RESP;
          else state_next = ffha_pkg::S_WALK;
        end else begin
          state_next = (faddr == '0 || count == '0) ? ffha_pkg::S_RESP : ffha_pkg::S_WALK;
        end
      end
      ffha_pkg::S_WALK: if (rv) begin
        if (op == ffha_pkg::CMD_ALLOC) begin
          if (fit) state_next = ffha_pkg::S_SHIFT;
          else if (last) state_next = brk_fit ? ffha_pkg::S_PLACE : ffha_pkg::S_RESP;
        end else begin
          if (match) state_next = last ? ffha_pkg::S_RESP : ffha_pkg::S_SHIFT;
          else if (last) state_next = ffha_pkg::S_RESP;
        end
      end
      ffha_pkg::S_SHIFT: if (!more && !rv) begin
        state_next = (op == ffha_pkg::CMD_ALLOC) ? ffha_pkg::S_PLACE : ffha_pkg::S_RESP;
      end
      ffha_pkg::S_PLACE: state_next = ffha_pkg::S_RESP;
      ffha_pkg::S_RESP:  if (res_take) state_next = ffha_pkg::S_IDLE;
      default:           state_next = ffha_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = (state == ffha_pkg::S_IDLE);
    res_valid     = (state == ffha_pkg::S_RESP);
    res           = '{data_address: r_addr, status: r_status};
    mem_req.raddr = ptr[IW-1:0];
    mem_req.we    = 1'b0;
    mem_req.waddr = eidx + IW'(1);
    mem_req.wdata = mem_rdata;
    unique case (state)
      ffha_pkg::S_SHIFT: begin
        mem_req.we    = rv;
        mem_req.waddr = (op == ffha_pkg::CMD_ALLOC) ? eidx + IW'(1) : eidx - IW'(1);
      end
      ffha_pkg::S_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos[IW-1:0];
        mem_req.wdata = {new_hdr, AW'(total - TW'(ffha_pkg::HEADER_BYTES))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_IDLE;
      count <= '0;
      brk   <= '0;
      rv    <= 1'b0;
      more  <= 1'b0;
    end else begin
      state <= state_next;
      if (start_evt.start_wr && count == '0) brk <= start_evt.value;
      unique case (state)
        ffha_pkg::S_IDLE: if (in_valid) begin
          op    <= command;
          total <= tot_in;
          faddr <= block_address;
        end
        ffha_pkg::S_START: begin
          r_addr   <= '0;
          ptr      <= '0;
          more     <= 1'b1;
          rv       <= 1'b0;
          pos      <= '0;
          new_hdr  <= heap_start;
          r_status <= (op == ffha_pkg::CMD_ALLOC)
                      ? ((count == CW'(ffha_pkg::MAX_BLOCKS)) ? ffha_pkg::ST_FULL
                                                              : ffha_pkg::ST_NOHEAP)
                      : ffha_pkg::ST_NOTFOUND;
        end
        ffha_pkg::S_WALK: begin
          // issue the next read while judging the entry that just came back
          if (more) begin
            ptr  <= ptr + CW'(1);
            more <= (ptr + CW'(1) < count);
            eidx <= ptr[IW-1:0];
          end
          rv <= more;
          if (rv) begin
            below_top <= top_e;
            if (state_next != ffha_pkg::S_WALK) begin
              rv <= 1'b0;
              if (op == ffha_pkg::CMD_ALLOC) begin
                if (fit) begin
                  pos     <= CW'(eidx);
                  new_hdr <= (eidx == '0) ? heap_start : below_top[AW-1:0];
                  ptr     <= count - CW'(1);
                  more    <= 1'b1;
                end else begin
                  pos     <= count;
                  new_hdr <= brk;
                end
              end else if (match) begin
                r_status <= ffha_pkg::ST_OK;
                if (last) begin
                  count <= count - CW'(1);
                  brk   <= (eidx == '0) ? heap_start : below_top[AW-1:0];
                end else begin
                  ptr  <= CW'(eidx) + CW'(1);
                  more <= 1'b1;
                end
              end
            end
          end
        end
        ffha_pkg::S_SHIFT: begin
          if (more) begin
            eidx <= ptr[IW-1:0];
            if (op == ffha_pkg::CMD_ALLOC) begin
              ptr  <= ptr - CW'(1);
              more <= (ptr != pos);
            end else begin
              ptr  <= ptr + CW'(1);
              more <= (ptr + CW'(1) < count);
            end
          end
          rv <= more;
          if (!more && !rv && op == ffha_pkg::CMD_FREE) count <= count - CW'(1);
        end
        ffha_pkg::S_PLACE: begin
          count    <= count + CW'(1);
          if (pos == count) brk <= new_hdr + AW'(total);
          r_addr   <= new_hdr + AW'(ffha_pkg::HEADER_BYTES);
          r_status <= ffha_pkg::ST_OK;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- test/tb_heap_model.sv -----
// Scoreboard class for the first-fit heap allocator testbench.
// Depends on ffha_pkg; holds its own copy of the table and registers.
package tb_heap_model;

  typedef struct packed {
    logic [31:0]       data_address;
    ffha_pkg::status_t status;
  } heap_answer_t;

  class heap_scoreboard;
    logic [31:0] start_addr, limit_addr, brk;
    logic [31:0] hdr_tab[ffha_pkg::MAX_BLOCKS];
    logic [31:0] size_tab[ffha_pkg::MAX_BLOCKS];
    int unsigned live;
    heap_answer_t pending[$];
    int errors;
    int allocs_ok, frees_ok, full_hits, noheap_hits, miss_hits;

    function new();
      start_addr = 0; limit_addr = 0; brk = 0; live = 0; errors = 0;
      allocs_ok = 0; frees_ok = 0; full_hits = 0; noheap_hits = 0; miss_hits = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == ffha_pkg::REG_HEAP_START) begin
        start_addr = val;
        if (live == 0) brk = val;
      end else begin
        limit_addr = val;
      end
    endfunction

    function logic [33:0] top_of(int i);
      return {2'b0, hdr_tab[i]} + ffha_pkg::HEADER_BYTES + size_tab[i];
    endfunction

    function void insert(int pos, logic [33:0] hdr, logic [33:0] total);
      for (int k = live; k > pos; k--) begin
        hdr_tab[k] = hdr_tab[k-1];
        size_tab[k] = size_tab[k-1];
      end
      hdr_tab[pos] = hdr[31:0];
      size_tab[pos] = 32'(total - ffha_pkg::HEADER_BYTES);
      live++;
    endfunction

    function heap_answer_t allocate(logic [31:0] size);
      heap_answer_t a;
      logic [33:0] total, t;
      a.data_address = 0;
      if (live >= ffha_pkg::MAX_BLOCKS) begin
        a.status = ffha_pkg::ST_FULL;
        return a;
      end
      total = {2'b0, size} + ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES - 1;
      total = total & ~34'(ffha_pkg::ALIGN_BYTES - 1);
      if (live == 0 || {2'b0, start_addr} + total < {2'b0, hdr_tab[0]}) begin
        if (live == 0 && {2'b0, start_addr} + total > {2'b0, limit_addr}) begin
          a.status = ffha_pkg::ST_NOHEAP;
          return a;
        end
        if (live == 0) brk = 32'(start_addr + total);
        insert(0, {2'b0, start_addr}, total);
        a.data_address = start_addr + ffha_pkg::HEADER_BYTES;
        a.status = ffha_pkg::ST_OK;
        return a;
      end
      for (int i = 0; i + 1 < live; i++) begin
        t = top_of(i);
        if (t + total <= {2'b0, hdr_tab[i+1]}) begin
          insert(i + 1, t, total);
          a.data_address = 32'(t + ffha_pkg::HEADER_BYTES);
          a.status = ffha_pkg::ST_OK;
          return a;
        end
      end
      if ({2'b0, brk} + total > {2'b0, limit_addr}) begin
        a.status = ffha_pkg::ST_NOHEAP;
        return a;
      end
      insert(live, {2'b0, brk}, total);
      a.data_address = brk + ffha_pkg::HEADER_BYTES;
      brk = 32'(brk + total);
      a.status = ffha_pkg::ST_OK;
      return a;
    endfunction

    function ffha_pkg::status_t release_block(logic [31:0] addr);
      int i;
      if (addr == 0) return ffha_pkg::ST_NOTFOUND;
      for (i = 0; i < live; i++)
        if ({2'b0, hdr_tab[i]} + ffha_pkg::HEADER_BYTES == {2'b0, addr}) break;
      if (i >= live) return ffha_pkg::ST_NOTFOUND;
      for (int k = i; k + 1 < live; k++) begin
        hdr_tab[k] = hdr_tab[k+1];
        size_tab[k] = size_tab[k+1];
      end
      live--;
      if (i == live) brk = (live == 0) ? start_addr : 32'(top_of(live - 1));
      return ffha_pkg::ST_OK;
    endfunction

    // note an accepted request word and queue its answer
    function void note_request(logic cmd, logic [31:0] size, logic [31:0] addr);
      heap_answer_t a;
      if (cmd == ffha_pkg::CMD_ALLOC) begin
        a = allocate(size);
      end else begin
        a.data_address = 0;
        a.status = release_block(addr);
      end
      case (a.status)
        ffha_pkg::ST_OK: if (cmd == ffha_pkg::CMD_ALLOC) allocs_ok++; else frees_ok++;
        ffha_pkg::ST_FULL: full_hits++;
        ffha_pkg::ST_NOHEAP: noheap_hits++;
        default: miss_hits++;
      endcase
      pending.push_back(a);
    endfunction

    function void check_answer(logic [31:0] daddr, logic [1:0] st);
      heap_answer_t e;
      if (pending.size() == 0) begin
        $error("unexpected response word: data_address %h status %0d", daddr, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (daddr !== e.data_address) begin
        $error("data_address: expected %h actual %h", e.data_address, daddr);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, st);
        errors++;
      end
    endfunction

    // pick a live data address, or 0 if none
    function logic [31:0] live_address();
      if (live == 0) return 0;
      return hdr_tab[$urandom_range(live - 1)] + ffha_pkg::HEADER_BYTES;
    endfunction
  endclass
endpackage

// ----- test/tb_top.sv -----
// Top of the first-fit heap allocator testbench: clock, reset, drivers, checks.
// Depends on ffha_pkg, the channel interfaces, tb_heap_model and the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  ffha_req_if req();
  ffha_rsp_if rsp();
  ffha_cfg_if cfg();

  first_fit_heap_allocator u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  tb_heap_model::heap_scoreboard heap_sb;
  int quiet_sender;   // when set, the sender never idles
  int quiet_receiver; // when set, the receiver never stalls at random
  int hold_off;       // cycles of forced back-pressure left
  int words_seen;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Keep the run bounded even if a handshake never completes.
  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, plus a long counted hold-off on request.
  initial begin
    rsp.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        rsp.ready <= 0;
        hold_off--;
      end else begin
        rsp.ready <= quiet_receiver || ($urandom_range(99) >= 16);
      end
    end
  end

  // Sample every response word at the rising edge and check it.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      heap_sb.check_answer(rsp.data_address, rsp.status);
      words_seen++;
    end
  end

  // Hand one request word to the block; idle first at random.
  task automatic send_request(logic cmd, logic [31:0] size, logic [31:0] addr);
    while (!quiet_sender && $urandom_range(99) < 16) begin
      req.valid <= 0;
      @(negedge clk);
    end
    req.valid <= 1;
    req.command <= cmd;
    req.request_size <= size;
    req.block_address <= addr;
    do @(posedge clk); while (!req.ready);
    heap_sb.note_request(cmd, size, addr);
    @(negedge clk);
  endtask

  // Drop valid, then wait until every answer is back and the engine is done.
  task automatic drain();
    int guard;
    req.valid <= 0;
    guard = 0;
    while (heap_sb.pending.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    heap_sb.write_reg(idx, val);
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
  endtask

  task automatic set_heap(logic [31:0] base, logic [31:0] lim);
    drain();
    write_reg(ffha_pkg::REG_HEAP_START, base);
    write_reg(ffha_pkg::REG_HEAP_LIMIT, lim);
  endtask

  // One random request: mostly allocate/free of live blocks, some noise.
  task automatic random_request(int big);
    int pick;
    logic [31:0] size;
    pick = $urandom_range(99);
    if (pick < 50) begin
      size = big ? $urandom() : $urandom_range(300);
      if (!big && $urandom_range(19) == 0) size = $urandom();
      send_request(ffha_pkg::CMD_ALLOC, size, $urandom());
    end else if (pick < 88) begin
      send_request(ffha_pkg::CMD_FREE, $urandom(), heap_sb.live_address());
    end else if (pick < 94) begin
      send_request(ffha_pkg::CMD_FREE, $urandom(), $urandom());
    end else begin
      send_request(ffha_pkg::CMD_FREE, $urandom(), 0);
    end
  endtask

  initial begin
    heap_sb = new();
    quiet_sender = 0;
    quiet_receiver = 0;
    hold_off = 0;
    words_seen = 0;
    req.valid = 0; req.command = ffha_pkg::CMD_ALLOC;
    req.request_size = 0; req.block_address = 0;
    cfg.valid = 0; cfg.index = ffha_pkg::REG_HEAP_START; cfg.data = 0;
    rst = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: zero limit means out of heap; free of zero and of junk.
    send_request(ffha_pkg::CMD_ALLOC, 0, 0);
    send_request(ffha_pkg::CMD_FREE, 0, 0);
    send_request(ffha_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_heap(32'h0000_1000, 32'hFFFF_FFFF);
    send_request(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 0);   // oversize
    send_request(ffha_pkg::CMD_ALLOC, 0, 0);
    send_request(ffha_pkg::CMD_ALLOC, 1, 0);
    send_request(ffha_pkg::CMD_ALLOC, 16, 0);
    send_request(ffha_pkg::CMD_ALLOC, 17, 0);
    send_request(ffha_pkg::CMD_FREE, 0, 32'h0000_1010);    // frees the first: gap below
    send_request(ffha_pkg::CMD_ALLOC, 0, 0);               // too big for the strict start test: goes at the break
    send_request(ffha_pkg::CMD_FREE, 0, 32'h0000_1030);    // matches no block: not found
    send_request(ffha_pkg::CMD_ALLOC, 5, 0);
    send_request(ffha_pkg::CMD_FREE, 0, 32'h0000_1050);    // matches no block either: not found
    send_request(ffha_pkg::CMD_FREE, 0, 32'h0000_1050);    // still unknown
    // Fill the table to see the full case, then empty it.
    quiet_sender = 1;
    repeat (64) send_request(ffha_pkg::CMD_ALLOC, 0, 0);
    quiet_sender = 0;
    while (heap_sb.live > 0) send_request(ffha_pkg::CMD_FREE, 0, heap_sb.live_address());
    // Start moved while blocks live, and the top of the address space.
    set_heap(32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_request(ffha_pkg::CMD_ALLOC, 32'h60, 0);
    send_request(ffha_pkg::CMD_ALLOC, 32'hF0, 0);
    drain();
    write_reg(ffha_pkg::REG_HEAP_START, 32'h0000_0008);
    send_request(ffha_pkg::CMD_ALLOC, 32'h10, 0);

    // Random phases over several heap windows.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_heap(32'h0000_0000, 32'h0000_4000);
        1: set_heap(32'h8000_0000, 32'h8000_0800);
        2: set_heap(32'h0001_0000, 32'hFFFF_FFFF);
        3: set_heap(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        default: set_heap(32'h0000_0040, 32'h0000_0040);
      endcase
      // Second phase runs with no idling on either side.
      quiet_sender = (phase == 1);
      quiet_receiver = (phase == 1);
      for (int n = 0; n < 180; n++) begin
        if (phase == 2 && n == 20) hold_off = 600;
        random_request(phase == 3 && n % 4 == 0);
      end
    end
    quiet_sender = 0;
    quiet_receiver = 0;
    drain();

    $display("Checked %0d response words: %0d allocs, %0d frees ok, %0d full, %0d no heap,",
             words_seen, heap_sb.allocs_ok, heap_sb.frees_ok, heap_sb.full_hits,
             heap_sb.noheap_hits);
    $display("%0d bad frees; heap windows from empty to the top of the address space.",
             heap_sb.miss_hits);
    if (heap_sb.errors == 0 && heap_sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/ffha_pkg.sv
hdl/ffha_req_if.sv
hdl/ffha_rsp_if.sv
hdl/ffha_cfg_if.sv
hdl/ffha_ram.sv
hdl/ffha_engine.sv
hdl/first_fit_heap_allocator.sv
test/tb_heap_model.sv
test/tb_top.sv
